[rtl/core/bds_pkg.sv]
//------------------------------------------------------------------------------
// bds_pkg: shared definitions of the block average downscaler
// Channel widths, register codes and reset values, the command word passed
// from the front to the back end, and the divide-by-block-area reciprocals.
//------------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

	// Sample and accumulator widths
	localparam int CH_W       = 8;
	localparam int SUM_W      = 16;
	localparam int NUM_CH     = 3;

	// Configuration port
	localparam int SCALE_W    = 5;
	localparam int DIM_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_FACTOR = 2'd0,
		CFG_FRAME_WIDTH  = 2'd1,
		CFG_FRAME_HEIGHT = 2'd2,
		CFG_COLOR_MODE   = 2'd3
	} cfg_idx_t;

	localparam logic [SCALE_W-1:0] SCALE_RST  = 5'd2;
	localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;
	localparam logic               COLOR_RST  = 1'b1;

	// Parameter defaults
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_FACTOR_DEF = 16;

	// Factor that selects the 1-2-1 x 1-2-1 weighting
	localparam logic [SCALE_W-1:0] GAUSS_FACTOR = 5'd3;

	// Depth of the queue between front and back end
	localparam int QUEUE_DEPTH = 4;

	// Quotient = (sum * recip) >> QSHIFT, exact for any 16-bit sum
	localparam int RECIP_W = 25;
	localparam int QSHIFT  = 24;

	// Effective factor and color mode
	typedef struct packed {
		logic [SCALE_W-1:0] factor;
		logic               rgb;
	} mode_t;

	// One accumulate operation on a line store entry
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            first;
		logic [1:0]      wshift;
		logic            emit;
		logic            row_end;
		logic            frame_end;
	} cmd_t;

	// floor(2^24 / area) + 1, area = F*F, or 16 for the weighted factor
	function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] f);
		logic [RECIP_W-1:0] r;
		case (f)
			5'd1:    r = 25'd16777217;
			5'd2:    r = 25'd4194305;
			5'd3:    r = 25'd1048577;
			5'd4:    r = 25'd1048577;
			5'd5:    r = 25'd671089;
			5'd6:    r = 25'd466034;
			5'd7:    r = 25'd342393;
			5'd8:    r = 25'd262145;
			5'd9:    r = 25'd207127;
			5'd10:   r = 25'd167773;
			5'd11:   r = 25'd138655;
			5'd12:   r = 25'd116509;
			5'd13:   r = 25'd99274;
			5'd14:   r = 25'd85599;
			5'd15:   r = 25'd74566;
			5'd16:   r = 25'd65537;
			default: r = 25'd16777217;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/bds_intf.sv]
//------------------------------------------------------------------------------
// bds_intf: stream and configuration interfaces of the downscaler
// Valid/ready channels for input pixels, output pixels and register writes.
//------------------------------------------------------------------------------
`default_nettype none

interface bds_pix_in_if;
	logic                     valid;
	logic                     ready;
	logic [bds_pkg::CH_W-1:0] red_in;
	logic [bds_pkg::CH_W-1:0] green_in;
	logic [bds_pkg::CH_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

interface bds_pix_out_if;
	logic                     valid;
	logic                     ready;
	logic [bds_pkg::CH_W-1:0] red_out;
	logic [bds_pkg::CH_W-1:0] green_out;
	logic [bds_pkg::CH_W-1:0] blue_out;
	logic                     row_end;
	logic                     frame_end;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output row_end, output frame_end, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input row_end, input frame_end, output ready);
endinterface

interface bds_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bds_pkg::CFG_IDX_W-1:0]  index;
	logic [bds_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/bds_queue.sv]
//------------------------------------------------------------------------------
// bds_queue: command queue between front and back end
// Small register FIFO; push and pop may happen in the same cycle.
//------------------------------------------------------------------------------
`default_nettype none

module bds_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bds_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             head_valid
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign full       = (count_q == NW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = slot_q[rd_ptr_q];

	// Store a pushed beat
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && head_valid})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/bds_front.sv]
//------------------------------------------------------------------------------
// bds_front: pixel position tracking and classification
// Follows the raster position, drops pixels outside whole blocks and issues
// one accumulate command per kept pixel into the queue.
//------------------------------------------------------------------------------
`default_nettype none

module bds_front #(
	parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH + 1),
	localparam int IW = $clog2(MAX_WIDTH),
	localparam int QW = IW + $bits(bds_pkg::cmd_t)
) (
	input  logic           clk,
	input  logic           arst_n,
	bds_pix_in_if.sink     pix_in,
	input  bds_pkg::mode_t mode,
	input  logic [CW-1:0]  frame_w,
	input  logic [CW-1:0]  frame_h,
	input  logic           restart,
	input  logic           q_full,
	output logic           q_push,
	output logic [QW-1:0]  q_data
);
	import bds_pkg::*;

	logic [CW-1:0] col_cnt_q;
	logic [CW-1:0] row_cnt_q;
	logic [CW-1:0] out_col_q;
	logic [CW-1:0] col_blk_q;
	logic [CW-1:0] row_blk_q;
	logic [3:0]    off_h_q;
	logic [3:0]    off_v_q;

	logic          in_fire;
	logic [CW:0]   fx;
	logic [CW:0]   wx;
	logic [CW:0]   hx;
	logic          col_ok;
	logic          row_ok;
	logic          col_last;
	logic          row_last;
	logic          h_wrap;
	logic          v_wrap;
	logic          line_end;
	logic          frame_last;
	logic          emit;
	cmd_t          cmd;

	assign pix_in.ready = !q_full;
	assign in_fire      = pix_in.valid && pix_in.ready;

	// Block bounds: a block counts only when it fits wholly in the frame
	assign fx       = (CW + 1)'(mode.factor);
	assign wx       = {1'b0, frame_w};
	assign hx       = {1'b0, frame_h};
	assign col_ok   = ({1'b0, col_blk_q} + fx) <= wx;
	assign row_ok   = ({1'b0, row_blk_q} + fx) <= hx;
	assign col_last = ({1'b0, col_blk_q} + fx + fx) > wx;
	assign row_last = ({1'b0, row_blk_q} + fx + fx) > hx;

	assign h_wrap     = ({1'b0, off_h_q} + 5'd1) == mode.factor;
	assign v_wrap     = ({1'b0, off_v_q} + 5'd1) == mode.factor;
	assign line_end   = ({1'b0, col_cnt_q} + 1'b1) >= wx;
	assign frame_last = ({1'b0, row_cnt_q} + 1'b1) >= hx;
	assign emit       = h_wrap && v_wrap;

	// Build the accumulate command
	always_comb begin
		cmd.red       = pix_in.red_in;
		cmd.green     = mode.rgb ? pix_in.green_in : '0;
		cmd.blue      = mode.rgb ? pix_in.blue_in : '0;
		cmd.first     = (off_h_q == '0) && (off_v_q == '0);
		cmd.wshift    = '0;
		if (mode.factor == GAUSS_FACTOR) begin
			cmd.wshift = {1'b0, off_h_q == 4'd1} + {1'b0, off_v_q == 4'd1};
		end
		cmd.emit      = emit;
		cmd.row_end   = emit && col_last;
		cmd.frame_end = emit && col_last && row_last;
	end

	assign q_push = in_fire && col_ok && row_ok;
	assign q_data = {out_col_q[IW-1:0], cmd};

	// Advance the raster position on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			out_col_q <= '0;
			col_blk_q <= '0;
			row_blk_q <= '0;
			off_h_q   <= '0;
			off_v_q   <= '0;
		end else if (restart) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			out_col_q <= '0;
			col_blk_q <= '0;
			row_blk_q <= '0;
			off_h_q   <= '0;
			off_v_q   <= '0;
		end else if (in_fire) begin
			if (line_end) begin
				col_cnt_q <= '0;
				out_col_q <= '0;
				col_blk_q <= '0;
				off_h_q   <= '0;
				if (frame_last) begin
					row_cnt_q <= '0;
					row_blk_q <= '0;
					off_v_q   <= '0;
				end else begin
					row_cnt_q <= row_cnt_q + 1'b1;
					if (v_wrap) begin
						off_v_q   <= '0;
						row_blk_q <= row_blk_q + fx[CW-1:0];
					end else begin
						off_v_q <= off_v_q + 1'b1;
					end
				end
			end else begin
				col_cnt_q <= col_cnt_q + 1'b1;
				if (h_wrap) begin
					off_h_q   <= '0;
					out_col_q <= out_col_q + 1'b1;
					col_blk_q <= col_blk_q + fx[CW-1:0];
				end else begin
					off_h_q <= off_h_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/bds_back.sv]
//------------------------------------------------------------------------------
// bds_back: line store accumulation and block average output
// Read-modify-write of the per-column sums, reciprocal scaling of finished
// blocks and the output register.
//------------------------------------------------------------------------------
`default_nettype none

module bds_back #(
	parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEF,
	localparam int IW = $clog2(MAX_WIDTH),
	localparam int QW = IW + $bits(bds_pkg::cmd_t)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  logic [QW-1:0]               q_data,
	output logic                        q_pop,
	input  logic [bds_pkg::SCALE_W-1:0] factor,
	bds_pix_out_if.source               pix_out
);
	import bds_pkg::*;

	localparam int CW_BITS = $bits(cmd_t);
	localparam int MW      = SUM_W + RECIP_W;

	logic [NUM_CH*SUM_W-1:0] line_mem [MAX_WIDTH];

	logic                    adv;
	logic [IW-1:0]           head_idx;

	// Stage 1: accumulate and write back
	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic [IW-1:0]           idx_s1;
	logic [NUM_CH*SUM_W-1:0] rd_s1;
	logic                    fwd_valid_q;
	logic [IW-1:0]           fwd_idx_q;
	logic [NUM_CH*SUM_W-1:0] fwd_sum_q;
	logic [NUM_CH*SUM_W-1:0] base;
	logic [NUM_CH*SUM_W-1:0] sum_word;
	logic [CH_W-1:0]         px [NUM_CH];

	// Stage 2: scale finished block
	logic                    valid_s2;
	logic [NUM_CH*SUM_W-1:0] sum_s2;
	logic                    row_end_s2;
	logic                    frame_end_s2;
	logic [RECIP_W-1:0]      recip_s2;
	logic [MW-1:0]           prod [NUM_CH];

	// Output register
	logic                    out_valid_q;
	logic [CH_W-1:0]         out_ch_q [NUM_CH];
	logic                    row_end_q;
	logic                    frame_end_q;

	// Move the whole back end when the output register can take a beat
	assign adv      = !out_valid_q || pix_out.ready;
	assign q_pop    = adv && q_valid;
	assign head_idx = q_data[QW-1 -: IW];

	// Line store: read at the queue head, write the updated sums of stage 1
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_s1 <= line_mem[head_idx];
		end
		if (adv && valid_s1) begin
			line_mem[idx_s1] <= sum_word;
		end
	end

	// Take the previous write when it hit the same entry; start from zero on the first pixel of a block
	always_comb begin
		base = rd_s1;
		if (fwd_valid_q && (fwd_idx_q == idx_s1)) begin
			base = fwd_sum_q;
		end
		if (cmd_s1.first) begin
			base = '0;
		end
	end

	assign px[0] = cmd_s1.red;
	assign px[1] = cmd_s1.green;
	assign px[2] = cmd_s1.blue;

	// Add the weighted sample per channel
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_word[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W]
				+ (SUM_W'(px[c]) << cmd_s1.wshift);
		end
	end

	// Multiply by the reciprocal of the block area
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			prod[c] = MW'(sum_s2[c*SUM_W +: SUM_W]) * MW'(recip_s2);
		end
	end

	// Hold stage payloads while stalled
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= cmd_t'(q_data[CW_BITS-1:0]);
			idx_s1 <= head_idx;
		end
		if (adv) begin
			fwd_idx_q    <= idx_s1;
			fwd_sum_q    <= sum_word;
			sum_s2       <= sum_word;
			row_end_s2   <= cmd_s1.row_end;
			frame_end_s2 <= cmd_s1.frame_end;
			recip_s2     <= recip_of(factor);
			for (int c = 0; c < NUM_CH; c++) begin
				out_ch_q[c] <= prod[c][QSHIFT +: CH_W];
			end
			row_end_q   <= row_end_s2;
			frame_end_q <= frame_end_s2;
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			fwd_valid_q <= valid_s1;
			valid_s2    <= valid_s1 && cmd_s1.emit;
			out_valid_q <= valid_s2;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.red_out   = out_ch_q[0];
	assign pix_out.green_out = out_ch_q[1];
	assign pix_out.blue_out  = out_ch_q[2];
	assign pix_out.row_end   = row_end_q;
	assign pix_out.frame_end = frame_end_q;

endmodule

`default_nettype wire

[rtl/core/block_average_downscaler.sv]
//------------------------------------------------------------------------------
// block_average_downscaler: FxF block average image downscaler
// Averages each FxF block of a raster pixel stream into one output pixel,
// with 1-2-1 weighting at factor 3.
//
//   channel   dir  beat contents
//   cfg       in   index, data (register write)
//   pix_in    in   red_in, green_in, blue_in
//   pix_out   out  red_out, green_out, blue_out, row_end, frame_end
//
// One input pixel per clock sustained; the line store has one read and one
// write port, and each kept pixel makes one read-modify-write of its entry.
// An output pixel is formed from the last pixel of its block via stage 1, stage 2 and the output register.
// No clearing pass after reset: the first pixel of a block overwrites its entry.
// A stalled output holds the back end; the four-entry queue then fills and
// pix_in.ready drops. A register write restarts the frame position.
//------------------------------------------------------------------------------
`default_nettype none

module block_average_downscaler #(
	parameter int MAX_WIDTH  = bds_pkg::MAX_WIDTH_DEF,
	parameter int MAX_FACTOR = bds_pkg::MAX_FACTOR_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bds_cfg_if.sink       cfg,
	bds_pix_in_if.sink    pix_in,
	bds_pix_out_if.source pix_out
);
	import bds_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int IW = $clog2(MAX_WIDTH);
	localparam int QW = IW + $bits(cmd_t);

	logic [SCALE_W-1:0] scale_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic               color_q;

	logic               cfg_fire;
	mode_t              mode;
	logic [CW-1:0]      frame_w;
	logic [CW-1:0]      frame_h;

	logic               q_push;
	logic [QW-1:0]      q_wdata;
	logic               q_full;
	logic               q_pop;
	logic [QW-1:0]      q_head;
	logic               q_valid;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid && cfg.ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SCALE_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			color_q  <= COLOR_RST;
		end else if (cfg_fire) begin
			case (cfg_idx_t'(cfg.index))
				CFG_SCALE_FACTOR: scale_q  <= cfg.data[SCALE_W-1:0];
				CFG_FRAME_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
				CFG_FRAME_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				CFG_COLOR_MODE:   color_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Clamp register values to the supported range
	always_comb begin
		mode.rgb = color_q;
		if (scale_q == '0) begin
			mode.factor = SCALE_W'(1);
		end else if (int'(scale_q) > MAX_FACTOR) begin
			mode.factor = SCALE_W'(MAX_FACTOR);
		end else begin
			mode.factor = scale_q;
		end
		if (width_q == '0) begin
			frame_w = CW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			frame_w = CW'(MAX_WIDTH);
		end else begin
			frame_w = CW'(width_q);
		end
		if (height_q == '0) begin
			frame_h = CW'(1);
		end else if (int'(height_q) > MAX_WIDTH) begin
			frame_h = CW'(MAX_WIDTH);
		end else begin
			frame_h = CW'(height_q);
		end
	end

	bds_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.mode    (mode),
		.frame_w (frame_w),
		.frame_h (frame_h),
		.restart (cfg_fire),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	bds_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head_data  (q_head),
		.head_valid (q_valid)
	);

	bds_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_head),
		.q_pop   (q_pop),
		.factor  (mode.factor),
		.pix_out (pix_out)
	);

endmodule

`default_nettype wire
